@@ rtl/tlar_pkg.sv @@
// Shared types, constants and the character ramp for the tile luma to ASCII core.
// Every rtl module imports this package; it depends on nothing else.
`timescale 1ns / 1ps

package tlar_pkg;

    localparam int MAX_TILE_COLS   = 128;
    localparam int MAX_LINE_PIXELS = 4096;
    localparam int RAMP_LENGTH     = 70;
    localparam int COL_W           = $clog2(MAX_TILE_COLS);
    localparam int FIFO_DEPTH      = 4;

    localparam logic [15:0] COEF_R = 16'd13933;
    localparam logic [15:0] COEF_G = 16'd46871;
    localparam logic [15:0] COEF_B = 16'd4732;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH    = 3'd0,
        CFG_IMAGE_HEIGHT   = 3'd1,
        CFG_TILE_COLS      = 3'd2,
        CFG_TILE_WIDTH     = 3'd3,
        CFG_TILE_HEIGHT_Q8 = 3'd4,
        CFG_TILE_ROWS      = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [6:0] char_code;
        logic       end_of_line;
    } t_char;

    // One classified pixel on its way from the front to the accumulator.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [7:0]       luma;
        logic             emit;
        logic             eol;
        logic [12:0]      wc;
        logic [12:0]      hc;
    } t_item;

    // Request from the accumulator to the divider.
    typedef struct packed {
        logic        start;
        logic [31:0] sum;
        logic [12:0] wc;
        logic [12:0] hc;
        logic        eol;
    } t_div_req;

    // Ramp from dark to light, as ASCII codes.
    localparam logic [6:0] RAMP_ROM [0:RAMP_LENGTH-1] = '{
        7'd36,  7'd64,  7'd66,  7'd37,  7'd56,  7'd38,  7'd87,  7'd77,  7'd35,  7'd42,
        7'd111, 7'd97,  7'd104, 7'd107, 7'd98,  7'd100, 7'd112, 7'd113, 7'd119, 7'd109,
        7'd90,  7'd79,  7'd48,  7'd81,  7'd76,  7'd67,  7'd74,  7'd85,  7'd89,  7'd88,
        7'd122, 7'd99,  7'd118, 7'd117, 7'd110, 7'd120, 7'd114, 7'd106, 7'd102, 7'd116,
        7'd47,  7'd92,  7'd124, 7'd40,  7'd41,  7'd49,  7'd123, 7'd125, 7'd91,  7'd93,
        7'd63,  7'd45,  7'd95,  7'd43,  7'd126, 7'd60,  7'd62,  7'd105, 7'd33,  7'd108,
        7'd73,  7'd59,  7'd58,  7'd44,  7'd34,  7'd94,  7'd96,  7'd39,  7'd46,  7'd32
    };

endpackage

@@ rtl/tlar_front.sv @@
// Front end: configuration registers, raster and tile position tracking, luma.
// Classifies each pixel and pushes it into the queue. Uses tlar_pkg.
`timescale 1ns / 1ps

module tlar_front
    import tlar_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_pixel      i_pixel,
    output logic        o_stall,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    logic [12:0] r_img_w, r_img_h, r_tile_w, r_rows;
    logic [7:0]  r_cols;
    logic [19:0] r_hq8;

    logic [11:0]      r_px, r_py, r_tri, r_rsl;
    logic [COL_W-1:0] r_tci;
    logic [19:0]      r_hi;   // (tile column + 1) * tile width
    logic [31:0]      r_acc;  // (tile row + 1) * tile height, Q8
    logic             r_dirty;

    logic [12:0] w_w, w_h, w_tw, w_rows;
    logic [7:0]  w_cols;
    logic [19:0] w_hq;

    logic [12:0] w_py_inc, w_x1p, w_y1p, w_hc_diff;
    logic        w_wrapx;
    logic [11:0] w_x, w_y;
    logic        w_col_adv, w_row_adv, w_last_line, w_last_col, w_eol;
    logic [COL_W-1:0] n_tci, w_tci_c;
    logic [19:0]      n_hi, w_x1, w_wdiff;
    logic [31:0]      n_acc;
    logic [11:0]      n_tri, n_rsl, n_px, n_py, w_tri_c;
    logic [12:0]      w_wc, w_hc;
    logic [20:0]      w_hi_prod;
    logic [32:0]      w_acc_prod;
    logic [23:0]      w_luma_sum;
    logic             w_accept;

    // Saturated views of the registers.
    assign w_w    = (r_img_w == '0) ? 13'd1 : ((r_img_w > 13'd4096) ? 13'd4096 : r_img_w);
    assign w_h    = (r_img_h == '0) ? 13'd1 : ((r_img_h > 13'd4096) ? 13'd4096 : r_img_h);
    assign w_tw   = (r_tile_w == '0) ? 13'd1 : ((r_tile_w > 13'd4096) ? 13'd4096 : r_tile_w);
    assign w_rows = (r_rows == '0) ? 13'd1 : ((r_rows > 13'd4096) ? 13'd4096 : r_rows);
    assign w_cols = (r_cols == '0) ? 8'd1
                  : ((r_cols > 8'(MAX_TILE_COLS)) ? 8'(MAX_TILE_COLS) : r_cols);
    assign w_hq   = (r_hq8 < 20'd256) ? 20'd256 : r_hq8;

    assign o_stall  = r_dirty || i_full;
    assign w_accept = i_valid && !o_stall;

    assign w_luma_sum = 24'(({16'b0, i_pixel.red} * {16'b0, COEF_R})
                          + ({16'b0, i_pixel.green} * {16'b0, COEF_G})
                          + ({16'b0, i_pixel.blue} * {16'b0, COEF_B}));

    always_comb begin
        // Position of this pixel, after wrapping a stale position.
        w_wrapx  = {1'b0, r_px} >= w_w;
        w_py_inc = {1'b0, r_py} + {12'b0, w_wrapx};
        w_y      = (w_py_inc >= w_h) ? 12'd0 : w_py_inc[11:0];
        w_x      = w_wrapx ? 12'd0 : r_px;

        w_col_adv = (w_x != '0) && (({1'b0, r_tci} + 8'd1) < w_cols)
                  && ({8'b0, w_x} >= r_hi);
        n_tci = r_tci;
        n_hi  = r_hi;
        if (w_x == '0) begin
            n_tci = '0;
            n_hi  = {7'b0, w_tw};
        end else if (w_col_adv) begin
            n_tci = r_tci + 1'b1;
            n_hi  = r_hi + {7'b0, w_tw};
        end

        w_row_adv = (w_x == '0) && (w_y != '0) && (({1'b0, r_tri} + 13'd1) < w_rows)
                  && ({12'b0, w_y} >= r_acc[31:8]);
        n_tri = r_tri;
        n_acc = r_acc;
        n_rsl = r_rsl;
        if (w_x == '0 && w_y == '0) begin
            n_tri = '0;
            n_acc = {12'b0, w_hq};
            n_rsl = '0;
        end else if (w_row_adv) begin
            n_tri = r_tri + 1'b1;
            n_acc = r_acc + {12'b0, w_hq};
            n_rsl = w_y;
        end

        w_x1p = {1'b0, w_x} + 13'd1;
        w_y1p = {1'b0, w_y} + 13'd1;
        w_eol = w_x1p >= w_w;
        w_last_col  = w_eol || ((({1'b0, n_tci} + 8'd1) < w_cols)
                    && ({7'b0, w_x1p} >= n_hi));
        w_last_line = (w_y1p >= w_h) || ((({1'b0, n_tri} + 13'd1) < w_rows)
                    && ({11'b0, w_y1p} >= n_acc[31:8]));

        // Tile extent in pixels and lines, at least one each.
        w_x1    = n_hi - {7'b0, w_tw};
        w_wdiff = {8'b0, w_x} - w_x1;
        w_wc    = (w_x1 > {8'b0, w_x}) ? 13'd1 : (w_wdiff[12:0] + 13'd1);
        w_hc_diff = {1'b0, w_y} - {1'b0, n_rsl};
        w_hc    = (n_rsl > w_y) ? 13'd1 : (w_hc_diff + 13'd1);

        if (w_eol) begin
            n_px = '0;
            n_py = (w_y1p >= w_h) ? 12'd0 : w_y1p[11:0];
        end else begin
            n_px = w_x1p[11:0];
            n_py = w_y;
        end

        // Setup after reset or a register write: clamp indexes, rebuild bounds.
        w_tci_c = ({1'b0, r_tci} >= w_cols) ? COL_W'(w_cols - 8'd1) : r_tci;
        w_tri_c = ({1'b0, r_tri} >= w_rows) ? 12'(w_rows - 13'd1) : r_tri;
        w_hi_prod  = 21'({1'b0, w_tci_c} + 8'd1) * 21'(w_tw);
        w_acc_prod = 33'({1'b0, w_tri_c} + 13'd1) * 33'(w_hq);
    end

    assign o_push        = w_accept;
    assign o_item.col    = n_tci;
    assign o_item.luma   = w_luma_sum[23:16];
    assign o_item.emit   = w_last_line && w_last_col;
    assign o_item.eol    = w_eol;
    assign o_item.wc     = w_wc;
    assign o_item.hc     = w_hc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= 13'd640;
            r_img_h  <= 13'd480;
            r_cols   <= 8'd80;
            r_tile_w <= 13'd8;
            r_hq8    <= 20'd6144;
            r_rows   <= 13'd20;
            r_dirty  <= 1'b1;
        end else begin
            r_dirty <= i_cfg_we;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:    r_img_w  <= i_cfg_data[12:0];
                    CFG_IMAGE_HEIGHT:   r_img_h  <= i_cfg_data[12:0];
                    CFG_TILE_COLS:      r_cols   <= i_cfg_data[7:0];
                    CFG_TILE_WIDTH:     r_tile_w <= i_cfg_data[12:0];
                    CFG_TILE_HEIGHT_Q8: r_hq8    <= i_cfg_data;
                    CFG_TILE_ROWS:      r_rows   <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px  <= '0;
            r_py  <= '0;
            r_tci <= '0;
            r_tri <= '0;
            r_rsl <= '0;
        end else if (r_dirty) begin
            r_tci <= w_tci_c;
            r_tri <= w_tri_c;
        end else if (w_accept) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_tci <= n_tci;
            r_tri <= n_tri;
            r_rsl <= n_rsl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dirty) begin
            r_hi  <= w_hi_prod[19:0];
            r_acc <= w_acc_prod[31:0];
        end else if (w_accept) begin
            r_hi  <= n_hi;
            r_acc <= n_acc;
        end
    end

endmodule

@@ rtl/tlar_fifo.sv @@
// Short queue of classified pixels between the front end and the accumulator.
// Uses the item type from tlar_pkg.
`timescale 1ns / 1ps

module tlar_fifo
    import tlar_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_item              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_count;

    assign o_full  = r_count == (PTR_W+1)'(FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ rtl/tlar_accum.sv @@
// Tile column accumulator: a sum memory with read-modify-write and forwarding.
// Hands finished tile sums to the divider. Uses tlar_pkg.
`timescale 1ns / 1ps

module tlar_accum
    import tlar_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_item    i_head,
    input  logic     i_head_vld,
    input  logic     i_div_busy,
    output logic     o_pop,
    output t_div_req o_req
);

    logic [31:0]      r_sums [MAX_TILE_COLS];
    logic [MAX_TILE_COLS-1:0] r_sum_vld;
    logic [31:0]      r_rd;
    logic             r_rdv;
    t_item            r_a;
    logic             r_a_vld;
    logic             r_fwd_vld;
    logic [COL_W-1:0] r_fwd_col;
    logic [31:0]      r_fwd_val;

    logic [31:0] w_old, w_sum, w_wr;

    // A tile-ending pixel enters only when the divider can take it.
    assign o_pop = i_head_vld
                && (!i_head.emit || (!i_div_busy && !(r_a_vld && r_a.emit)));

    // The memory read misses the write of the item just before; forward it.
    assign w_old = (r_fwd_vld && r_fwd_col == r_a.col) ? r_fwd_val
                 : (r_rdv ? r_rd : 32'd0);
    assign w_sum = w_old + {24'b0, r_a.luma};
    assign w_wr  = r_a.emit ? 32'd0 : w_sum;

    assign o_req.start = r_a_vld && r_a.emit;
    assign o_req.sum   = w_sum;
    assign o_req.wc    = r_a.wc;
    assign o_req.hc    = r_a.hc;
    assign o_req.eol   = r_a.eol;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_sums[i_head.col];
        end
        if (r_a_vld) begin
            r_sums[r_a.col] <= w_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
            r_a_vld   <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_a_vld <= o_pop;
            if (r_a_vld) begin
                r_sum_vld[r_a.col] <= 1'b1;
                r_fwd_vld          <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a   <= i_head;
            r_rdv <= r_sum_vld[i_head.col];
        end
        if (r_a_vld) begin
            r_fwd_col <= r_a.col;
            r_fwd_val <= w_wr;
        end
    end

endmodule

@@ rtl/tlar_div.sv @@
// Restoring divider for the tile average, ramp lookup and the output register.
// One quotient bit per cycle. Uses tlar_pkg.
`timescale 1ns / 1ps

module tlar_div
    import tlar_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    input  logic     i_stall,
    output logic     o_busy,
    output logic     o_valid,
    output t_char    o_char
);

    t_div_state r_state, n_state;
    logic [31:0] r_num;
    logic [24:0] r_den, r_rem;
    logic [4:0]  r_cnt;
    logic        r_eol;
    logic        r_out_vld;
    t_char       r_out;

    logic [25:0] w_shift;
    logic        w_ge;
    logic [25:0] w_rem_sub;
    logic [32:0] w_avg;
    logic [14:0] w_prod, w_q255;
    logic [6:0]  w_idx;
    logic        w_load;
    logic [25:0] w_den_prod;

    assign w_shift   = {r_rem, r_num[31]};
    assign w_ge      = w_shift >= {1'b0, r_den};
    assign w_rem_sub = w_shift - {1'b0, r_den};
    assign w_den_prod = 26'(i_req.wc) * 26'(i_req.hc);

    // Index 69*avg/255; for avg of 255 or more it saturates at the ramp end.
    assign w_avg  = {1'b0, r_num} + 33'd1;
    assign w_prod = 15'(w_avg[7:0]) * 15'd69;
    assign w_q255 = (w_prod + (w_prod >> 8) + 15'd1) >> 8;
    assign w_idx  = (w_avg >= 33'd255) ? 7'(RAMP_LENGTH - 1) : w_q255[6:0];

    assign w_load  = (r_state == DIV_DONE) && (!r_out_vld || !i_stall);
    assign o_busy  = r_state != DIV_IDLE;
    assign o_valid = r_out_vld;
    assign o_char  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: begin
                if (i_req.start) begin
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (r_cnt == 5'd31) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                if (w_load) begin
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE && i_req.start) begin
            r_num <= i_req.sum;
            r_den <= w_den_prod[24:0];
            r_rem <= '0;
            r_cnt <= '0;
            r_eol <= i_req.eol;
        end else if (r_state == DIV_RUN) begin
            r_num <= {r_num[30:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[24:0] : w_shift[24:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.char_code <= RAMP_ROM[w_idx];
            r_out.end_of_line <= r_eol;
        end
    end

endmodule

@@ rtl/tile_luma_to_ascii_ramp_core.sv @@
// Takes one pixel per cycle while not stalled; its luma passes the queue and the accumulate
// stage register before it reaches the column sum. A tile character passes the queue,
// one accumulate stage, the restoring divider, its done state and the output register.
// The divider handles one tile at a time, so closely spaced tile ends stall.
// Reset is synchronous: positions clear, registers take defaults, and the block stalls
// input for setup after reset and after each register write.
`timescale 1ns / 1ps

module tile_luma_to_ascii_ramp_core
    import tlar_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_pixel      i_pixel,
    output logic        o_stall,
    output logic        o_valid,
    output t_char       o_char,
    input  logic        i_stall,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    logic     w_push, w_pop, w_full, w_empty, w_div_busy;
    t_item    w_item, w_head;
    t_div_req w_req;

    tlar_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .o_stall     (o_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_item)
    );

    tlar_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_item  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tlar_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_head_vld (!w_empty),
        .i_div_busy (w_div_busy),
        .o_pop      (w_pop),
        .o_req      (w_req)
    );

    tlar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_stall (i_stall),
        .o_busy  (w_div_busy),
        .o_valid (o_valid),
        .o_char  (o_char)
    );

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_div_busy)
        else $error("divider started while busy");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue push while full");

    a_setup_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_stall)
        else $error("input not held during setup after register write");

endmodule

@@ tb/tlar_checker.sv @@
// Checker for tile_luma_to_ascii_ramp_core: mirrors the register writes, predicts one
// character per finished tile and compares the accepted output characters. Depends on tlar_pkg.
`timescale 1ns / 1ps

module tlar_checker
    import tlar_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_pixel      i_pixel,
    input  logic        i_in_stall,
    input  logic        i_out_valid,
    input  t_char       i_char,
    input  logic        i_out_stall,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef longint unsigned t_u64;

    logic [31:0] col_sum [MAX_TILE_COLS];
    t_u64 pos_x, pos_y, cur_col, cur_row, row_first_line;
    t_u64 reg_w, reg_h, reg_cols, reg_tw, reg_hq8, reg_rows;
    t_char char_queue [$];

    function automatic t_u64 clamp(t_u64 v, t_u64 lo, t_u64 hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Advances the raster position by one pixel; returns 1 when a tile completes.
    function automatic bit tile_step(t_pixel p, output t_char c);
        t_u64 w, h, cols, tw, hq8, rows, x, y, luma, x1, wc, hc, avg, idx;
        bit last_line, last_col;
        w = clamp(reg_w, 1, MAX_LINE_PIXELS);
        h = clamp(reg_h, 1, MAX_LINE_PIXELS);
        cols = clamp(reg_cols, 1, MAX_TILE_COLS);
        tw = clamp(reg_tw, 1, MAX_LINE_PIXELS);
        hq8 = (reg_hq8 < 256) ? 256 : reg_hq8;
        rows = clamp(reg_rows, 1, MAX_LINE_PIXELS);
        luma = (13933 * t_u64'(p.red) + 46871 * t_u64'(p.green)
                + 4732 * t_u64'(p.blue)) >> 16;
        c = '0;
        if (pos_x >= w) begin
            pos_x = 0;
            pos_y++;
        end
        if (pos_y >= h) pos_y = 0;
        x = pos_x;
        y = pos_y;
        if (x == 0) begin
            if (y == 0) begin
                cur_row = 0;
                row_first_line = 0;
            end else if (cur_row + 1 < rows && y >= (((cur_row + 1) * hq8) >> 8)) begin
                cur_row++;
                row_first_line = y;
            end
            cur_col = 0;
        end else if (cur_col + 1 < cols && x >= (cur_col + 1) * tw) begin
            cur_col++;
        end
        if (cur_col >= cols) cur_col = cols - 1;
        if (cur_row >= rows) cur_row = rows - 1;
        col_sum[cur_col] = col_sum[cur_col] + 32'(luma);
        last_line = (y + 1 >= h) ||
                    (cur_row + 1 < rows && y + 1 >= (((cur_row + 1) * hq8) >> 8));
        last_col = (x + 1 >= w) || (cur_col + 1 < cols && x + 1 >= (cur_col + 1) * tw);
        pos_x = x + 1;
        if (pos_x >= w) begin
            pos_x = 0;
            pos_y = y + 1;
            if (pos_y >= h) pos_y = 0;
        end
        if (!(last_line && last_col)) return 0;
        x1 = cur_col * tw;
        wc = (x1 > x) ? 1 : x - x1 + 1;
        hc = (row_first_line > y) ? 1 : y - row_first_line + 1;
        avg = t_u64'(col_sum[cur_col]) / (wc * hc) + 1;
        idx = ((RAMP_LENGTH - 1) * avg) / 255;
        if (idx >= RAMP_LENGTH) idx = RAMP_LENGTH - 1;
        c.char_code = RAMP_ROM[idx];
        c.end_of_line = (x + 1 >= w);
        col_sum[cur_col] = '0;
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_char want, got;
        if (!i_rst_n) begin
            foreach (col_sum[k]) col_sum[k] = '0;
            pos_x = 0; pos_y = 0; cur_col = 0; cur_row = 0; row_first_line = 0;
            reg_w = 640; reg_h = 480; reg_cols = 80;
            reg_tw = 8; reg_hq8 = 6144; reg_rows = 20;
            char_queue.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:    reg_w = i_cfg_data[12:0];
                    CFG_IMAGE_HEIGHT:   reg_h = i_cfg_data[12:0];
                    CFG_TILE_COLS:      reg_cols = i_cfg_data[7:0];
                    CFG_TILE_WIDTH:     reg_tw = i_cfg_data[12:0];
                    CFG_TILE_HEIGHT_Q8: reg_hq8 = i_cfg_data;
                    CFG_TILE_ROWS:      reg_rows = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_char;
                if (char_queue.size() == 0) begin
                    if (o_errors < 10)
                        $display("ERROR: unexpected character %0d eol %0b",
                                 got.char_code, got.end_of_line);
                    o_errors <= o_errors + 1;
                end else begin
                    want = char_queue.pop_front();
                    if (want != got) begin
                        if (o_errors < 10)
                            $display("ERROR: char exp %0d act %0d, eol exp %0b act %0b",
                                     want.char_code, got.char_code,
                                     want.end_of_line, got.end_of_line);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                if (tile_step(i_pixel, want)) char_queue.push_back(want);
            end
        end
        o_pending <= char_queue.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the tile luma to ASCII testbench: clock, reset, register setup and pixel
// stimulus per phase. Depends on tlar_pkg, the core and tlar_checker.
`timescale 1ns / 1ps

module testbench;
    import tlar_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_pixel      i_pixel = '0;
    logic        o_stall;
    logic        o_valid;
    t_char       o_char;
    logic        i_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;
    int          errors, pending;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          pixels_sent = 0;

    always #2 i_clk = ~i_clk;

    tile_luma_to_ascii_ramp_core u_top (.*);

    tlar_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_pixel(i_pixel),
        .i_in_stall(o_stall), .i_out_valid(o_valid), .i_char(o_char),
        .i_out_stall(i_stall), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_errors(errors), .o_pending(pending)
    );

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value[19:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned cols,
                             int unsigned tw, int unsigned hq8, int unsigned rows);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_TILE_COLS, cols);
        write_reg(CFG_TILE_WIDTH, tw);
        write_reg(CFG_TILE_HEIGHT_Q8, hq8);
        write_reg(CFG_TILE_ROWS, rows);
    endtask

    // Holds the request until the core takes it. A call made right at a falling
    // edge drives in that same cycle, so consecutive calls run back to back.
    task automatic send_pixel(t_pixel p);
        if (i_clk) @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_pixel = p;
        do @(posedge i_clk); while (o_stall);
        pixels_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic t_pixel rand_pixel();
        return t_pixel'($urandom_range(24'hFFFFFF));
    endfunction

    // A tile may still be in the divider when the queue is empty.
    task automatic drain();
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        t_pixel directed [$];
        int phase, n;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Two-pixel tiles so every second pixel completes one.
        set_frame(4, 2, 2, 2, 256, 2);
        directed = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFF0000,
                     24'h00FF00, 24'h0000FF, 24'h000000, 24'h808080, 24'h7F7F7F,
                     24'hFF00FF, 24'h00FFFF, 24'h010101, 24'hFEFEFE, 24'h000000,
                     24'hFFFF00};
        foreach (directed[k]) send_pixel(directed[k]);
        drain();

        // Lower extremes: every register out of range low, one-pixel tiles.
        set_frame(0, 0, 0, 0, 0, 0);
        for (int k = 0; k < 20; k++) send_pixel(rand_pixel());
        drain();

        // Upper extremes: widest line, one text row, clamped column count.
        // Only the first quarter of the line is sent.
        send_idle_pct = 13;
        stall_pct = 13;
        set_frame(8191, 1, 255, 32, 20'hFFFFF, 8191);
        for (int k = 0; k < 1024; k++) send_pixel(rand_pixel());
        drain();

        phase = 0;
        while (pixels_sent < 1950) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            // Phases are not frame aligned, so later frames start mid-image.
            set_frame($urandom_range(12, 1), $urandom_range(8, 1), $urandom_range(6, 1),
                      $urandom_range(5, 1), $urandom_range(1200, 256),
                      $urandom_range(5, 1));
            n = $urandom_range(200, 60);
            for (int k = 0; k < n; k++) begin
                send_pixel(rand_pixel());
                if (phase == 3 && k == n / 2) wait (pending == 0);
            end
            drain();
            phase++;
        end

        fork
            begin
                wait (pending == 0);
                repeat (100) @(posedge i_clk);
            end
            begin
                repeat (20000) @(posedge i_clk);
            end
        join_any
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
